### design/spatial_chunk_hash_table_defines.svh
// Assertion macros shared by the spatial chunk hash table RTL.
// No dependencies; included by the files that carry concurrent assertions.
`ifndef SPATIAL_CHUNK_HASH_TABLE_DEFINES_SVH
`define SPATIAL_CHUNK_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SCHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SCHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/scht_pkg.sv
// Shared constants and types of the spatial chunk hash table.
// No dependencies; compiled before every other file of the block.
package scht_pkg;

    localparam int KEY_IN_W     = 26;
    localparam int HANDLE_OUT_W = 13;

    // Hash weights of the x, y and z coordinates.
    localparam int HASH_MUL_X = 19;
    localparam int HASH_MUL_Y = 7;
    localparam int HASH_MUL_Z = 3;

    typedef struct packed {
        logic                    found;
        logic                    inserted;
        logic [HANDLE_OUT_W-1:0] entry_handle;
        logic                    pool_full;
    } t_result;

endpackage

### design/scht_ifs.sv
// Valid/ready channel interfaces for requests and responses of the hash table.
// Depends on scht_pkg for the payload widths.
interface scht_req_if;
    import scht_pkg::*;

    logic                       valid;
    logic                       ready;
    logic                       req_type;
    logic signed [KEY_IN_W-1:0] key_x;
    logic signed [KEY_IN_W-1:0] key_y;
    logic signed [KEY_IN_W-1:0] key_z;

    modport source (output valid, req_type, key_x, key_y, key_z, input ready);
    modport sink   (input valid, req_type, key_x, key_y, key_z, output ready);
endinterface

interface scht_rsp_if;
    import scht_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    found;
    logic                    inserted;
    logic [HANDLE_OUT_W-1:0] entry_handle;
    logic                    pool_full;

    modport source (output valid, found, inserted, entry_handle, pool_full, input ready);
    modport sink   (input valid, found, inserted, entry_handle, pool_full, output ready);
endinterface

### design/scht_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
module scht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### design/scht_hash.sv
// Key preparation and slot hash: sign-extends the coordinates from KEY_BITS
// and forms 19x + 7y + 3z reduced to a primary slot. Depends on scht_pkg.
module scht_hash #(
    parameter int KEY_BITS      = 26,
    parameter int PRIMARY_SLOTS = 4096
) (
    input  logic signed [scht_pkg::KEY_IN_W-1:0]  i_key_x,
    input  logic signed [scht_pkg::KEY_IN_W-1:0]  i_key_y,
    input  logic signed [scht_pkg::KEY_IN_W-1:0]  i_key_z,
    output logic [KEY_BITS-1:0]                   o_key_x,
    output logic [KEY_BITS-1:0]                   o_key_y,
    output logic [KEY_BITS-1:0]                   o_key_z,
    output logic [$clog2(PRIMARY_SLOTS)-1:0]      o_slot
);
    import scht_pkg::*;

    localparam int SLOT_W = $clog2(PRIMARY_SLOTS);

    logic signed [31:0]         w_wide_x, w_wide_y, w_wide_z;
    logic signed [KEY_BITS-1:0] w_k_x, w_k_y, w_k_z;
    logic signed [31:0]         w_s_x, w_s_y, w_s_z;
    logic [SLOT_W-1:0]          w_sum;

    assign w_wide_x = 32'(i_key_x);
    assign w_wide_y = 32'(i_key_y);
    assign w_wide_z = 32'(i_key_z);

    assign w_k_x = w_wide_x[KEY_BITS-1:0];
    assign w_k_y = w_wide_y[KEY_BITS-1:0];
    assign w_k_z = w_wide_z[KEY_BITS-1:0];

    assign w_s_x = 32'(w_k_x);
    assign w_s_y = 32'(w_k_y);
    assign w_s_z = 32'(w_k_z);

    // Only the low slot bits of the 32-bit wrapping sum reach the mask, so
    // the sum is formed at that width.
    assign w_sum = SLOT_W'(HASH_MUL_X) * w_s_x[SLOT_W-1:0]
                 + SLOT_W'(HASH_MUL_Y) * w_s_y[SLOT_W-1:0]
                 + SLOT_W'(HASH_MUL_Z) * w_s_z[SLOT_W-1:0];

    // Masking with the slot count minus one already keeps the index in range.
    assign o_slot  = w_sum & SLOT_W'(PRIMARY_SLOTS - 1);
    assign o_key_x = w_k_x;
    assign o_key_y = w_k_y;
    assign o_key_z = w_k_z;
endmodule

### design/spatial_chunk_hash_table.sv
// Chained hash table on three signed chunk coordinates, one entry RAM.
// A request walks the chain in S_CMP with one entry RAM read per chain link, then goes
// through S_OUT, which loads the registered response; appending an overflow entry adds
// S_FILL before S_OUT. A new request is taken only back in S_IDLE, once the previous one
// is through, and is held off longer while a finished response still waits for ready.
// After reset the primary slots are cleared one by one in S_CLEAR with the request
// channel not ready; pool entries are written when they are handed out.
`include "spatial_chunk_hash_table_defines.svh"

module spatial_chunk_hash_table #(
    parameter int PRIMARY_SLOTS = 4096,
    parameter int POOL_ENTRIES  = 1024,
    parameter int KEY_BITS      = 26
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    scht_req_if.sink    i_req,
    scht_rsp_if.source  o_rsp
);
    import scht_pkg::*;

    localparam int TOTAL      = PRIMARY_SLOTS + POOL_ENTRIES;
    localparam int SLOT_W     = $clog2(PRIMARY_SLOTS);
    localparam int HANDLE_W   = $clog2(TOTAL);
    localparam int POOL_CNT_W = $clog2(POOL_ENTRIES + 1);
    localparam int LINK_LSB   = 3 * KEY_BITS;
    localparam int VALID_BIT  = LINK_LSB + HANDLE_W;
    localparam int WORD_W     = VALID_BIT + 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_FILL  = 3'd3;
    localparam logic [2:0] S_OUT   = 3'd4;

    logic [2:0]            r_state, n_state;
    logic [SLOT_W-1:0]     r_clr, n_clr;
    logic                  r_insert, n_insert;
    logic [KEY_BITS-1:0]   r_kx, n_kx, r_ky, n_ky, r_kz, n_kz;
    logic [HANDLE_W-1:0]   r_addr, n_addr;
    logic [POOL_CNT_W-1:0] r_pool_used, n_pool_used;
    t_result               r_res, n_res;
    t_result               r_out, n_out;
    logic                  r_out_valid, n_out_valid;

    logic [KEY_BITS-1:0]   w_hx, w_hy, w_hz;
    logic [SLOT_W-1:0]     w_slot;

    logic                  w_we, w_re;
    logic [HANDLE_W-1:0]   w_waddr, w_raddr;
    logic [WORD_W-1:0]     w_wdata, w_rdata;

    logic                  w_rd_valid;
    logic [HANDLE_W-1:0]   w_rd_link;
    logic [KEY_BITS-1:0]   w_rd_kx, w_rd_ky, w_rd_kz;
    logic                  w_match;
    logic [HANDLE_W-1:0]   w_new_h;
    logic                  w_out_free;

    scht_hash #(
        .KEY_BITS      (KEY_BITS),
        .PRIMARY_SLOTS (PRIMARY_SLOTS)
    ) u_hash (
        .i_key_x (i_req.key_x),
        .i_key_y (i_req.key_y),
        .i_key_z (i_req.key_z),
        .o_key_x (w_hx),
        .o_key_y (w_hy),
        .o_key_z (w_hz),
        .o_slot  (w_slot)
    );

    scht_ram #(
        .WIDTH (WORD_W),
        .DEPTH (TOTAL)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    assign w_rd_valid = w_rdata[VALID_BIT];
    assign w_rd_link  = w_rdata[VALID_BIT-1:LINK_LSB];
    assign w_rd_kx    = w_rdata[3*KEY_BITS-1:2*KEY_BITS];
    assign w_rd_ky    = w_rdata[2*KEY_BITS-1:KEY_BITS];
    assign w_rd_kz    = w_rdata[KEY_BITS-1:0];
    assign w_match    = (w_rd_kx == r_kx) && (w_rd_ky == r_ky) && (w_rd_kz == r_kz);
    assign w_new_h    = HANDLE_W'(PRIMARY_SLOTS) + HANDLE_W'(r_pool_used);
    assign w_out_free = !r_out_valid || o_rsp.ready;

    assign i_req.ready = (r_state == S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_insert    = r_insert;
        n_kx        = r_kx;
        n_ky        = r_ky;
        n_kz        = r_kz;
        n_addr      = r_addr;
        n_pool_used = r_pool_used;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid && !o_rsp.ready;
        w_we        = 1'b0;
        w_waddr     = r_addr;
        w_wdata     = {1'b1, HANDLE_W'(0), r_kx, r_ky, r_kz};
        w_re        = 1'b0;
        w_raddr     = HANDLE_W'(w_slot);

        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = HANDLE_W'(r_clr);
                w_wdata = '0;
                n_clr   = r_clr + SLOT_W'(1);
                if (r_clr == SLOT_W'(PRIMARY_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    w_re     = 1'b1;
                    n_addr   = HANDLE_W'(w_slot);
                    n_insert = i_req.req_type;
                    n_kx     = w_hx;
                    n_ky     = w_hy;
                    n_kz     = w_hz;
                    n_state  = S_CMP;
                end
            end
            S_CMP: begin
                n_res   = '0;
                n_state = S_OUT;
                if (!w_rd_valid) begin
                    if (r_insert) begin
                        w_we  = 1'b1;
                        n_res = '{found: 1'b1, inserted: 1'b1,
                                  entry_handle: HANDLE_OUT_W'(r_addr), pool_full: 1'b0};
                    end
                end else if (w_match) begin
                    n_res = '{found: 1'b1, inserted: 1'b0,
                              entry_handle: HANDLE_OUT_W'(r_addr), pool_full: 1'b0};
                end else if (w_rd_link == '0) begin
                    // End of the chain: on an insert, append a pool entry behind this one unless the pool is full.
                    if (r_insert) begin
                        if (r_pool_used >= POOL_CNT_W'(POOL_ENTRIES)) begin
                            n_res.pool_full = 1'b1;
                        end else begin
                            w_we        = 1'b1;
                            w_wdata     = {1'b1, w_new_h, w_rd_kx, w_rd_ky, w_rd_kz};
                            n_addr      = w_new_h;
                            n_pool_used = r_pool_used + POOL_CNT_W'(1);
                            n_res       = '{found: 1'b1, inserted: 1'b1,
                                            entry_handle: HANDLE_OUT_W'(w_new_h),
                                            pool_full: 1'b0};
                            n_state     = S_FILL;
                        end
                    end
                end else if ({1'b0, w_rd_link} < (HANDLE_W + 1)'(TOTAL)) begin
                    w_re    = 1'b1;
                    w_raddr = w_rd_link;
                    n_addr  = w_rd_link;
                    n_state = S_CMP;
                end
            end
            S_FILL: begin
                w_we    = 1'b1;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
                n_clr   = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_pool_used <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_pool_used <= n_pool_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_insert <= n_insert;
        r_kx     <= n_kx;
        r_ky     <= n_ky;
        r_kz     <= n_kz;
        r_addr   <= n_addr;
        r_res    <= n_res;
        r_out    <= n_out;
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out.found;
    assign o_rsp.inserted     = r_out.inserted;
    assign o_rsp.entry_handle = r_out.entry_handle;
    assign o_rsp.pool_full    = r_out.pool_full;

    `SCHT_ASSERT_IMPL(a_no_rw_same_entry, i_clk, i_rst_n, w_we && w_re, w_waddr != w_raddr, "read and write of one entry in the same cycle")
    `SCHT_ASSERT_IMPL(a_pool_bound, i_clk, i_rst_n, 1'b1, r_pool_used <= POOL_CNT_W'(POOL_ENTRIES), "pool counter beyond pool size")
    `SCHT_ASSERT_IMPL(a_fill_after_alloc, i_clk, i_rst_n, r_state == S_FILL, r_pool_used == $past(r_pool_used) + POOL_CNT_W'(1), "pool entry filled without allocation")
    `SCHT_ASSERT_IMPL(a_result_coherent, i_clk, i_rst_n, r_out_valid, (r_out.found || !r_out.inserted) && !(r_out.found && r_out.pool_full), "inconsistent result flags")
    `SCHT_ASSERT_NEXT(a_result_loaded, i_clk, i_rst_n, (r_state == S_OUT) && w_out_free, r_out_valid && (r_state == S_IDLE), "finished result not presented")
endmodule
